// ----- rtl/hpw_pkg.sv -----
// shared types and constants of the heartbeat ping watchdog
`default_nettype none

package hpw_pkg;

    localparam int unsigned CFG_AW = 4;
    localparam int unsigned CFG_DW = 32;

    localparam logic [31:0] PING_INTERVAL_RST = 32'd100;
    localparam logic [31:0] PONG_TIMEOUT_RST  = 32'd50;
    localparam logic [7:0]  MISS_LIMIT_RST    = 8'd3;
    localparam logic [31:0] FIRST_NONCE       = 32'd1;
    localparam logic [7:0]  MISS_MAX          = 8'hFF;

    typedef enum logic [2:0] {
        KIND_TICK    = 3'd0,
        KIND_ALLOC   = 3'd1,
        KIND_PING    = 3'd2,
        KIND_PONG    = 3'd3,
        KIND_RESTART = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FLIGHT = 2'd1,
        PH_KILL   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        REG_PING_INTERVAL = 2'd0,
        REG_PONG_TIMEOUT  = 2'd1,
        REG_MISS_LIMIT    = 2'd2
    } t_reg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] now;
        logic [31:0] nonce;
    } t_in_word;

    typedef struct packed {
        logic        ping_due;
        logic        kill_requested;
        logic [31:0] allocated_nonce;
        logic [1:0]  phase;
        logic [7:0]  miss_count;
        logic [31:0] kill_total;
    } t_out_word;

endpackage

`default_nettype wire

// ----- rtl/heartbeat_ping_watchdog.sv -----
// heartbeat ping watchdog top level: input register, event logic, result register
// Each event word passes the input register, then the result register; a new word can
// be accepted every cycle while the result is not stalled. The input register holds the
// event, the watchdog state is updated at the same edge that loads the result register,
// so the next event already sees the new state. One 64-bit time difference feeds both the
// pong timeout and the ping-due compare. Configuration is written over the APB port at
// byte addresses 0, 4 and 8 (ping_interval, pong_timeout, miss_limit) and is read back there.
`default_nettype none

module heartbeat_ping_watchdog (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  hpw_pkg::t_in_word          i_in_word,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output hpw_pkg::t_out_word               o_out_word,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [hpw_pkg::CFG_AW-1:0]       paddr,
    input  wire  [hpw_pkg::CFG_DW-1:0]       pwdata,
    output logic [hpw_pkg::CFG_DW-1:0]       prdata,
    output logic                             pready
);
    import hpw_pkg::*;

    logic [31:0] r_ping_interval;
    logic [31:0] r_pong_timeout;
    logic [7:0]  r_miss_limit;

    logic        r_in_valid;
    t_in_word    r_in;
    logic        r_out_valid;
    t_out_word   r_out;

    t_phase      r_phase,   n_phase;
    logic [31:0] r_pending, n_pending;
    logic [31:0] r_next,    n_next;
    logic [63:0] r_last,    n_last;
    logic [7:0]  r_misses,  n_misses;
    logic [31:0] r_kills,   n_kills;

    logic        move;
    logic        cfg_wr;
    logic [63:0] diff;
    logic [7:0]  miss_inc;
    logic [31:0] alloc;
    logic        last_is_now;
    logic        due;
    t_out_word   res;

    assign move       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !move;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            REG_PING_INTERVAL: prdata = r_ping_interval;
            REG_PONG_TIMEOUT:  prdata = r_pong_timeout;
            REG_MISS_LIMIT:    prdata = {24'd0, r_miss_limit};
            default:           prdata = '0;
        endcase
    end

    assign diff     = r_in.now - r_last;
    assign miss_inc = (r_misses == MISS_MAX) ? r_misses : r_misses + 8'd1;

    always_comb begin
        n_phase     = r_phase;
        n_pending   = r_pending;
        n_next      = r_next;
        n_last      = r_last;
        n_misses    = r_misses;
        n_kills     = r_kills;
        alloc       = '0;
        last_is_now = 1'b0;
        case (r_in.kind)
            KIND_TICK: begin
                if (r_phase == PH_FLIGHT && diff >= {32'd0, r_pong_timeout}) begin
                    n_misses  = miss_inc;
                    n_pending = '0;
                    if (miss_inc >= r_miss_limit) begin
                        n_phase = PH_KILL;
                    end else begin
                        n_phase     = PH_IDLE;
                        n_last      = r_in.now;
                        last_is_now = 1'b1;
                    end
                end
            end
            KIND_ALLOC: begin
                alloc  = r_next;
                n_next = (r_next == 32'hFFFF_FFFF) ? FIRST_NONCE : r_next + 32'd1;
            end
            KIND_PING: begin
                if (r_phase != PH_KILL) begin
                    n_phase     = PH_FLIGHT;
                    n_pending   = r_in.nonce;
                    n_last      = r_in.now;
                    last_is_now = 1'b1;
                end
            end
            KIND_PONG: begin
                if (r_phase == PH_FLIGHT && r_in.nonce == r_pending) begin
                    n_phase   = PH_IDLE;
                    n_pending = '0;
                    n_misses  = '0;
                end
            end
            KIND_RESTART: begin
                n_kills     = r_kills + 32'd1;
                n_phase     = PH_IDLE;
                n_pending   = '0;
                n_last      = r_in.now;
                last_is_now = 1'b1;
                n_misses    = '0;
            end
            default: begin
            end
        endcase
        due = (n_phase == PH_IDLE) &&
              (last_is_now ? (r_ping_interval == 32'd0) : (diff >= {32'd0, r_ping_interval}));
        res.ping_due        = due;
        res.kill_requested  = (n_phase == PH_KILL);
        res.allocated_nonce = alloc;
        res.phase           = n_phase;
        res.miss_count      = n_misses;
        res.kill_total      = n_kills;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ping_interval <= PING_INTERVAL_RST;
            r_pong_timeout  <= PONG_TIMEOUT_RST;
            r_miss_limit    <= MISS_LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_PING_INTERVAL: r_ping_interval <= pwdata;
                REG_PONG_TIMEOUT:  r_pong_timeout  <= pwdata;
                REG_MISS_LIMIT:    r_miss_limit    <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_pending   <= '0;
            r_next      <= FIRST_NONCE;
            r_last      <= '0;
            r_misses    <= '0;
            r_kills     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_pending   <= n_pending;
                r_next      <= n_next;
                r_last      <= n_last;
                r_misses    <= n_misses;
                r_kills     <= n_kills;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (move) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hpw_chk.sv -----
// port-level checker of the heartbeat ping watchdog and its bind
`default_nettype none

module hpw_chk (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          o_out_valid,
    input  wire                          i_out_stall,
    input  wire  hpw_pkg::t_out_word     o_out_word
);
    import hpw_pkg::*;

    logic        r_have_prev;
    logic [31:0] r_prev_kills;
    logic        out_take;

    assign out_take = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev  <= 1'b0;
            r_prev_kills <= '0;
        end else if (out_take) begin
            r_have_prev  <= 1'b1;
            r_prev_kills <= o_out_word.kill_total;
        end
    end

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    a_kill_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.kill_requested == (o_out_word.phase == PH_KILL)))
        else $error("kill flag disagrees with phase");

    a_due_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.ping_due) |-> (o_out_word.phase == PH_IDLE))
        else $error("ping due outside idle");

    // kill total moves by at most one per word
    a_kill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && r_have_prev) |->
            (o_out_word.kill_total == r_prev_kills ||
             o_out_word.kill_total == r_prev_kills + 32'd1))
        else $error("kill total jumped");

endmodule

bind heartbeat_ping_watchdog hpw_chk u_hpw_chk (.*);

`default_nettype wire

// ----- tb/heartbeat_ping_watchdog_tb.sv -----
// self-checking testbench for the heartbeat ping watchdog with its own status predictor
`timescale 1ns / 1ps

module heartbeat_ping_watchdog_tb;
    import hpw_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 10;
    localparam int STUCK_LIMIT  = 3000;
    localparam int PHASE_WORDS  = 205;
    localparam int MAX_REPORTS  = 10;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CFG_AW-1:0]   paddr = '0;
    logic [CFG_DW-1:0]   pwdata = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    heartbeat_ping_watchdog u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predicted watchdog state and configuration
    logic [31:0] cfg_interval   = PING_INTERVAL_RST;
    logic [31:0] cfg_timeout    = PONG_TIMEOUT_RST;
    logic [7:0]  cfg_miss_limit = MISS_LIMIT_RST;
    t_phase      wd_phase       = PH_IDLE;
    logic [31:0] wd_pending     = '0;
    logic [31:0] wd_next_nonce  = FIRST_NONCE;
    logic [63:0] wd_last_ping   = '0;
    logic [7:0]  wd_misses      = '0;
    logic [31:0] wd_kills       = '0;

    t_in_word  event_q[$];
    t_out_word status_q[$];
    int        mismatch_count = 0;
    int        stuck_cycles = 0;
    int        send_gap = 0;
    int        stall_left = 0;
    int        stall_roll;
    logic      sender_idles = 1'b1;
    logic      receiver_idles = 1'b1;
    logic [63:0] gen_time = '0;
    logic [31:0] gen_nonce = FIRST_NONCE;

    function automatic t_out_word watchdog_step(t_in_word w);
        t_out_word   r;
        logic [31:0] handed;
        logic [63:0] since;
        handed = '0;
        case (w.kind)
            KIND_TICK: begin
                if (wd_phase == PH_FLIGHT && (w.now - wd_last_ping) >= {32'd0, cfg_timeout}) begin
                    if (wd_misses != MISS_MAX) begin
                        wd_misses = wd_misses + 8'd1;
                    end
                    wd_pending = '0;
                    if (wd_misses >= cfg_miss_limit) begin
                        wd_phase = PH_KILL;
                    end else begin
                        wd_phase = PH_IDLE;
                        wd_last_ping = w.now;
                    end
                end
            end
            KIND_ALLOC: begin
                handed = wd_next_nonce;
                wd_next_nonce = wd_next_nonce + 32'd1;
                if (wd_next_nonce == '0) begin
                    wd_next_nonce = FIRST_NONCE;
                end
            end
            KIND_PING: begin
                if (wd_phase != PH_KILL) begin
                    wd_phase = PH_FLIGHT;
                    wd_pending = w.nonce;
                    wd_last_ping = w.now;
                end
            end
            KIND_PONG: begin
                if (wd_phase == PH_FLIGHT && w.nonce == wd_pending) begin
                    wd_phase = PH_IDLE;
                    wd_pending = '0;
                    wd_misses = '0;
                end
            end
            KIND_RESTART: begin
                wd_kills = wd_kills + 32'd1;
                wd_phase = PH_IDLE;
                wd_pending = '0;
                wd_last_ping = w.now;
                wd_misses = '0;
            end
            default: ;
        endcase
        since = w.now - wd_last_ping;
        r.ping_due        = (wd_phase == PH_IDLE) && (since >= {32'd0, cfg_interval});
        r.kill_requested  = (wd_phase == PH_KILL);
        r.allocated_nonce = handed;
        r.phase           = wd_phase;
        r.miss_count      = wd_misses;
        r.kill_total      = wd_kills;
        return r;
    endfunction

    function automatic int pick_gap(logic idles);
        int roll;
        roll = $urandom_range(0, 99);
        if (!idles || roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // time step that lands within one of the given threshold half of the time
    function automatic logic [63:0] pick_delta(logic [31:0] span_base);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) begin
            return 64'($urandom_range(0, (span_base > 32'd200) ? 200 : span_base));
        end else if (roll < 9) begin
            return {32'd0, span_base} + 64'($urandom_range(0, 2)) - 64'd1;
        end
        return {32'd0, $urandom};
    endfunction

    task automatic queue_evt(logic [2:0] k, logic [63:0] t, logic [31:0] n);
        t_in_word w;
        w.kind = k;
        w.now = t;
        w.nonce = n;
        event_q.push_back(w);
    endtask

    task automatic queue_session();
        logic [31:0] ping_nonce;
        int          outcome;
        int          ticks;
        gen_time = gen_time + pick_delta(cfg_interval);
        queue_evt(KIND_TICK, gen_time, $urandom);
        if ($urandom_range(0, 9) < 8) begin
            queue_evt(KIND_ALLOC, gen_time, $urandom);
            ping_nonce = gen_nonce;
            gen_nonce = gen_nonce + 32'd1;
            if (gen_nonce == '0) begin
                gen_nonce = FIRST_NONCE;
            end
        end else begin
            ping_nonce = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
        end
        queue_evt(KIND_PING, gen_time, ping_nonce);
        outcome = $urandom_range(0, 9);
        ticks = $urandom_range(0, 2);
        repeat (ticks) begin
            gen_time = gen_time + 64'($urandom_range(0, (cfg_timeout > 32'd200) ? 200 :
                                                       cfg_timeout));
            queue_evt(KIND_TICK, gen_time, $urandom);
        end
        if (outcome < 5) begin
            if ($urandom_range(0, 3) == 0) begin
                queue_evt(KIND_PONG, gen_time, ping_nonce ^ (32'd1 << $urandom_range(0, 31)));
            end
            queue_evt(KIND_PONG, gen_time, ping_nonce);
        end else if (outcome < 9) begin
            gen_time = gen_time + pick_delta(cfg_timeout);
            queue_evt(KIND_TICK, gen_time, $urandom);
            if ($urandom_range(0, 3) == 0) begin
                queue_evt(KIND_PONG, gen_time, ping_nonce);
            end
        end else begin
            ping_nonce = $urandom;
            gen_time = gen_time + 64'($urandom_range(0, 20));
            queue_evt(KIND_PING, gen_time, ping_nonce);
            queue_evt(KIND_PONG, gen_time, ping_nonce);
        end
        if ($urandom_range(0, 99) < 12) begin
            queue_evt(KIND_RESTART, gen_time, $urandom);
        end
    endtask

    task automatic queue_phase();
        while (event_q.size() < PHASE_WORDS) begin
            if ($urandom_range(0, 99) < 15) begin
                queue_evt(3'($urandom_range(0, 7)),
                          ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : gen_time,
                          $urandom);
            end else begin
                queue_session();
            end
        end
    endtask

    task automatic wait_drain();
        do begin
            @(negedge i_clk);
        end while (event_q.size() != 0 || in_valid || status_q.size() != 0);
    endtask

    task automatic cfg_write(t_reg idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PING_INTERVAL: cfg_interval = value;
            REG_PONG_TIMEOUT:  cfg_timeout = value;
            REG_MISS_LIMIT:    cfg_miss_limit = value[7:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(int idx, logic [31:0] interval, logic [31:0] timeout,
                             logic [7:0] limit);
        wait_drain();
        cfg_write(REG_PING_INTERVAL, interval);
        cfg_write(REG_PONG_TIMEOUT, timeout);
        cfg_write(REG_MISS_LIMIT, {24'd0, limit});
        sender_idles = (idx % 3 != 1);
        receiver_idles = (idx % 3 != 2);
        @(negedge i_clk);
        queue_phase();
    endtask

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // driver: one event word per handshake, random gaps between words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_valid && !in_stall) begin
                status_q.push_back(watchdog_step(in_word));
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end else if (event_q.size() != 0) begin
                    in_word <= event_q.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_gap(sender_idles);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
            if (receiver_idles) begin
                stall_roll = $urandom_range(0, 99);
                if (stall_roll < 15) begin
                    stall_left = $urandom_range(1, 3);
                end else if (stall_roll < 18) begin
                    stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    // monitor: compare each status word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            if (status_q.size() == 0) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("status word with nothing expected: %p", out_word);
                end
                mismatch_count = mismatch_count + 1;
            end else if (out_word.ping_due !== status_q[0].ping_due ||
                         out_word.kill_requested !== status_q[0].kill_requested ||
                         out_word.allocated_nonce !== status_q[0].allocated_nonce ||
                         out_word.phase !== status_q[0].phase ||
                         out_word.miss_count !== status_q[0].miss_count ||
                         out_word.kill_total !== status_q[0].kill_total) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("status mismatch at %0t: expected %p, got %p",
                             $realtime, status_q[0], out_word);
                end
                mismatch_count = mismatch_count + 1;
                void'(status_q.pop_front());
            end else begin
                void'(status_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles = stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int k;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words at reset configuration
        queue_evt(KIND_TICK, 64'd0, 32'd0);
        queue_evt(KIND_TICK, 64'd100, 32'd0);
        queue_evt(KIND_ALLOC, 64'd100, 32'd0);
        queue_evt(KIND_PONG, 64'd100, 32'd1);
        queue_evt(KIND_PING, 64'd100, 32'd1);
        queue_evt(KIND_PING, 64'd110, 32'd0);
        queue_evt(KIND_PONG, 64'd120, 32'd1);
        queue_evt(KIND_TICK, 64'd159, 32'd0);
        queue_evt(KIND_PONG, 64'd160, 32'd0);
        queue_evt(KIND_PING, 64'd200, 32'hFFFF_FFFF);
        queue_evt(KIND_TICK, 64'd250, 32'd0);
        queue_evt(KIND_PING, 64'd260, 32'd5);
        queue_evt(KIND_TICK, 64'd310, 32'd0);
        queue_evt(KIND_PING, 64'd320, 32'd6);
        queue_evt(KIND_TICK, 64'd370, 32'd0);
        queue_evt(KIND_PING, 64'd380, 32'd7);
        queue_evt(KIND_PONG, 64'd390, 32'd6);
        queue_evt(KIND_TICK, 64'd500, 32'd0);
        for (k = KIND_RESTART + 1; k < 8; k++) begin
            queue_evt(3'(k), '1, '1);
        end
        queue_evt(KIND_RESTART, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        queue_evt(KIND_TICK, 64'd0, 32'd0);
        queue_evt(KIND_TICK, 64'd99, 32'd0);
        queue_evt(KIND_ALLOC, 64'd99, 32'd0);
        queue_evt(KIND_RESTART, 64'd120, 32'd0);
        gen_nonce = 32'd3;
        gen_time = 64'd120;

        run_phase(1, 32'd20, 32'd10, 8'd2);
        run_phase(2, 32'd0, 32'd0, 8'd1);
        run_phase(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        run_phase(4, $urandom_range(0, 300), $urandom_range(0, 150), 8'd0);
        run_phase(5, $urandom_range(1, 60), $urandom_range(1, 40), 8'($urandom_range(1, 6)));
        gen_time = {$urandom, $urandom};
        run_phase(6, $urandom, $urandom, 8'($urandom_range(1, 255)));

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && status_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- heartbeat_ping_watchdog.f -----
rtl/hpw_pkg.sv
rtl/heartbeat_ping_watchdog.sv
rtl/hpw_chk.sv
tb/heartbeat_ping_watchdog_tb.sv
